@@ rtl/k_way_sorted_merge_core_assert.svh @@
// Assertion macros for the k-way sorted merge core.
// Expects clk and rst_n in the scope of every use.
`ifndef K_WAY_SORTED_MERGE_CORE_ASSERT_SVH
`define K_WAY_SORTED_MERGE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/kwm_pkg.sv @@
// Shared constants and types of the k-way sorted merge core.
// Used by the controller, the datapath and the top level.
package kwm_pkg;

    localparam int MAX_LISTS    = 8;
    localparam int BUFFER_DEPTH = 8;
    localparam int VALUE_WIDTH  = 32;

    localparam int ID_W      = 3;
    localparam int CFG_W     = 4;
    localparam int LID_W     = $clog2(MAX_LISTS);
    localparam int PTR_W     = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CNT_W     = $clog2(BUFFER_DEPTH + 1);
    localparam int RAM_AW    = LID_W + PTR_W;
    localparam int RAM_DEPTH = 1 << RAM_AW;

    typedef struct packed {
        logic [ID_W-1:0]               list_id;
        logic signed [VALUE_WIDTH-1:0] value;
        logic                          carries_value;
        logic                          closes_list;
    } in_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] out_value;
        logic                          batch_end;
        logic                          dropped;
    } out_t;

    typedef struct packed {
        logic accept;
        logic load_drop;
        logic eval;
        logic emit;
        logic refill;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic item_drop;
        logic out_free;
        logic any;
        logic blocked;
        logic all_closed;
        logic last;
        logic refill;
    } status_t;

endpackage

@@ rtl/kwm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module kwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/kwm_ctrl.sv @@
// Sequencing state machine of the k-way sorted merge core.
// Depends on kwm_pkg and k_way_sorted_merge_core_assert.svh.
`include "k_way_sorted_merge_core_assert.svh"

module kwm_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  kwm_pkg::status_t status,
    output kwm_pkg::cmd_t    cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DROP   = 3'd1;
    localparam logic [2:0] S_EVAL   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_REFILL = 3'd4;

    logic [2:0] state_reg, state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = status.item_drop ? S_DROP : S_EVAL;
                end
            end
            S_DROP:
            begin
                if (status.out_free)
                begin
                    cmd.load_drop = 1'b1;
                    state_next    = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (!status.any)
                begin
                    // Nothing buffered: a fully closed batch ends without a result.
                    cmd.clear  = status.all_closed;
                    state_next = S_IDLE;
                end
                else if (status.blocked)
                begin
                    state_next = S_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (status.refill)
                    begin
                        state_next = S_REFILL;
                    end
                    else
                    begin
                        state_next = S_EVAL;
                    end
                end
            end
            S_REFILL:
            begin
                cmd.refill = 1'b1;
                state_next = S_EVAL;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `ASSERT_IMPL(a_load_needs_slot, cmd.emit || cmd.load_drop, status.out_free)
    `ASSERT_IMPL(a_refill_after_emit, state_reg == S_REFILL, $past(cmd.emit))
    `ASSERT_NEXT(a_accept_moves_on, cmd.accept, state_reg == S_DROP || state_reg == S_EVAL)

endmodule

@@ rtl/kwm_dp.sv @@
// Datapath of the k-way sorted merge core: list buffers, heads, min tree, output register.
// Depends on kwm_pkg, kwm_ram and k_way_sorted_merge_core_assert.svh.
`include "k_way_sorted_merge_core_assert.svh"

module kwm_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [kwm_pkg::CFG_W-1:0]      cfg_wr_data,
    input  kwm_pkg::in_t                   in_data,
    input  kwm_pkg::cmd_t                  cmd,
    output kwm_pkg::status_t               status,
    output logic                           out_valid,
    input  logic                           out_stall,
    output kwm_pkg::out_t                  out_data
);

    localparam int LEAF  = 1 << kwm_pkg::LID_W;
    localparam int NODES = 2 * LEAF - 1;

    function automatic logic [kwm_pkg::PTR_W-1:0] ptr_inc(input logic [kwm_pkg::PTR_W-1:0] p);
        logic [kwm_pkg::PTR_W-1:0] r;
        if (p == kwm_pkg::PTR_W'(kwm_pkg::BUFFER_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + kwm_pkg::PTR_W'(1);
        end
        return r;
    endfunction

    logic [kwm_pkg::CNT_W-1:0]       cnt_reg   [kwm_pkg::MAX_LISTS];
    logic [kwm_pkg::CNT_W-1:0]       cnt_next  [kwm_pkg::MAX_LISTS];
    logic [kwm_pkg::PTR_W-1:0]       rdptr_reg [kwm_pkg::MAX_LISTS];
    logic [kwm_pkg::PTR_W-1:0]       rdptr_next[kwm_pkg::MAX_LISTS];
    logic [kwm_pkg::MAX_LISTS-1:0]   closed_reg, closed_next;
    logic [kwm_pkg::CFG_W-1:0]       n_eff_reg, n_eff_next;
    logic signed [kwm_pkg::VALUE_WIDTH-1:0] head_reg [kwm_pkg::MAX_LISTS];
    logic signed [kwm_pkg::VALUE_WIDTH-1:0] drop_val_reg;

    logic [kwm_pkg::LID_W-1:0]       best_reg;
    logic                            any_reg, blocked_reg, allc_reg, last_reg, refill_reg;
    logic                            out_valid_reg;
    kwm_pkg::out_t                   out_reg;

    logic [kwm_pkg::MAX_LISTS-1:0]   in_use, nonempty, nonempty_use;
    logic [kwm_pkg::LID_W-1:0]       lid;
    logic                            id_ok, full, wr_ok;
    logic [kwm_pkg::CNT_W:0]         wr_sum;
    logic [kwm_pkg::PTR_W-1:0]       wr_pos;
    logic                            out_free, over_cap;

    logic                            node_ok [NODES];
    logic [kwm_pkg::LID_W-1:0]       node_id [NODES];
    logic signed [kwm_pkg::VALUE_WIDTH-1:0] node_v [NODES];
    logic                            t_any, t_blocked, t_allc, t_last, t_refill;
    logic [kwm_pkg::LID_W-1:0]       t_best;

    logic [kwm_pkg::VALUE_WIDTH-1:0] ram_rdata;
    logic [kwm_pkg::CFG_W-1:0]       cfg_clamped;

    always_comb
    begin
        for (int i = 0; i < kwm_pkg::MAX_LISTS; i++)
        begin
            in_use[i]   = (kwm_pkg::CFG_W'(i) < n_eff_reg);
            nonempty[i] = (cnt_reg[i] != '0);
        end
        nonempty_use = nonempty & in_use;
        over_cap     = 1'b0;
        for (int i = 0; i < kwm_pkg::MAX_LISTS; i++)
        begin
            if (cnt_reg[i] > kwm_pkg::CNT_W'(kwm_pkg::BUFFER_DEPTH))
            begin
                over_cap = 1'b1;
            end
        end
    end

    // Input item checks and the write position inside the list's ring.
    always_comb
    begin
        lid    = in_data.list_id[kwm_pkg::LID_W-1:0];
        id_ok  = (kwm_pkg::CFG_W'(in_data.list_id) < n_eff_reg);
        full   = (cnt_reg[lid] == kwm_pkg::CNT_W'(kwm_pkg::BUFFER_DEPTH));
        wr_ok  = in_data.carries_value && id_ok && !closed_reg[lid] && !full;
        wr_sum = (kwm_pkg::CNT_W + 1)'(rdptr_reg[lid]) + (kwm_pkg::CNT_W + 1)'(cnt_reg[lid]);
        if (wr_sum >= (kwm_pkg::CNT_W + 1)'(kwm_pkg::BUFFER_DEPTH))
        begin
            wr_sum = wr_sum - (kwm_pkg::CNT_W + 1)'(kwm_pkg::BUFFER_DEPTH);
        end
        wr_pos = wr_sum[kwm_pkg::PTR_W-1:0];
    end

    // Minimum tree over the buffered heads; on a tie the lower list id wins.
    always_comb
    begin
        for (int j = 0; j < LEAF; j++)
        begin
            node_ok[LEAF-1+j] = 1'b0;
            node_id[LEAF-1+j] = kwm_pkg::LID_W'(j);
            node_v[LEAF-1+j]  = '0;
            if (j < kwm_pkg::MAX_LISTS)
            begin
                node_ok[LEAF-1+j] = nonempty_use[j];
                node_v[LEAF-1+j]  = head_reg[j];
            end
        end
        for (int n = LEAF - 2; n >= 0; n--)
        begin
            if (node_ok[2*n+2] && (!node_ok[2*n+1] || (node_v[2*n+2] < node_v[2*n+1])))
            begin
                node_ok[n] = 1'b1;
                node_id[n] = node_id[2*n+2];
                node_v[n]  = node_v[2*n+2];
            end
            else
            begin
                node_ok[n] = node_ok[2*n+1];
                node_id[n] = node_id[2*n+1];
                node_v[n]  = node_v[2*n+1];
            end
        end
        t_best    = node_id[0];
        t_any     = node_ok[0];
        t_blocked = |(in_use & ~nonempty & ~closed_reg);
        t_allc    = ((closed_reg & in_use) == in_use);
        t_last    = t_allc && ($countones(nonempty_use) == 1) &&
                    (cnt_reg[t_best] == kwm_pkg::CNT_W'(1));
        t_refill  = (cnt_reg[t_best] > kwm_pkg::CNT_W'(1));
    end

    always_comb
    begin
        if (cfg_wr_data == '0)
        begin
            cfg_clamped = kwm_pkg::CFG_W'(1);
        end
        else if (cfg_wr_data > kwm_pkg::CFG_W'(kwm_pkg::MAX_LISTS))
        begin
            cfg_clamped = kwm_pkg::CFG_W'(kwm_pkg::MAX_LISTS);
        end
        else
        begin
            cfg_clamped = cfg_wr_data;
        end
    end

    always_comb
    begin
        cnt_next    = cnt_reg;
        rdptr_next  = rdptr_reg;
        closed_next = closed_reg;
        n_eff_next  = n_eff_reg;
        if (cmd.accept)
        begin
            if (wr_ok)
            begin
                cnt_next[lid] = cnt_reg[lid] + kwm_pkg::CNT_W'(1);
            end
            if (in_data.closes_list && id_ok)
            begin
                closed_next[lid] = 1'b1;
            end
        end
        if (cmd.emit)
        begin
            cnt_next[best_reg]   = cnt_reg[best_reg] - kwm_pkg::CNT_W'(1);
            rdptr_next[best_reg] = ptr_inc(rdptr_reg[best_reg]);
        end
        if (cmd.clear || (cmd.emit && last_reg) || cfg_wr_en)
        begin
            for (int i = 0; i < kwm_pkg::MAX_LISTS; i++)
            begin
                cnt_next[i]   = '0;
                rdptr_next[i] = '0;
            end
            closed_next = '0;
        end
        if (cfg_wr_en)
        begin
            n_eff_next = cfg_clamped;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < kwm_pkg::MAX_LISTS; i++)
            begin
                cnt_reg[i]   <= '0;
                rdptr_reg[i] <= '0;
            end
            closed_reg    <= '0;
            n_eff_reg     <= kwm_pkg::CFG_W'(kwm_pkg::MAX_LISTS);
            best_reg      <= '0;
            any_reg       <= 1'b0;
            blocked_reg   <= 1'b0;
            allc_reg      <= 1'b0;
            last_reg      <= 1'b0;
            refill_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            rdptr_reg  <= rdptr_next;
            closed_reg <= closed_next;
            n_eff_reg  <= n_eff_next;
            if (cmd.eval)
            begin
                best_reg    <= t_best;
                any_reg     <= t_any;
                blocked_reg <= t_blocked;
                allc_reg    <= t_allc;
                last_reg    <= t_last;
                refill_reg  <= t_refill;
            end
            if (cmd.emit || cmd.load_drop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            drop_val_reg <= in_data.value;
            if (wr_ok && (cnt_reg[lid] == '0))
            begin
                head_reg[lid] <= in_data.value;
            end
        end
        if (cmd.refill)
        begin
            head_reg[best_reg] <= ram_rdata;
        end
        if (cmd.load_drop)
        begin
            out_reg.out_value <= drop_val_reg;
            out_reg.batch_end <= 1'b0;
            out_reg.dropped   <= 1'b1;
        end
        else if (cmd.emit)
        begin
            out_reg.out_value <= head_reg[best_reg];
            out_reg.batch_end <= last_reg;
            out_reg.dropped   <= 1'b0;
        end
    end

    kwm_ram #(
        .WIDTH (kwm_pkg::VALUE_WIDTH),
        .DEPTH (kwm_pkg::RAM_DEPTH)
    ) u_buf_ram (
        .clk   (clk),
        .we    (cmd.accept && wr_ok),
        .waddr ({lid, wr_pos}),
        .wdata (in_data.value),
        .re    (cmd.emit),
        .raddr ({best_reg, ptr_inc(rdptr_reg[best_reg])}),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        status.item_drop  = in_data.carries_value && !wr_ok;
        status.out_free   = out_free;
        status.any        = any_reg;
        status.blocked    = blocked_reg;
        status.all_closed = allc_reg;
        status.last       = last_reg;
        status.refill     = refill_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `ASSERT_NEXT(a_clear_empties, cmd.clear || cfg_wr_en, nonempty == '0 && closed_reg == '0)
    `ASSERT_IMPL(a_no_overflow, 1'b1, !over_cap)
    `ASSERT_IMPL(a_drop_not_end, out_valid_reg && out_reg.dropped, !out_reg.batch_end)

endmodule

@@ rtl/k_way_sorted_merge_core.sv @@
// Top level of the k-way sorted merge core.
// Depends on kwm_pkg, kwm_ctrl and kwm_dp.
//
// Usage: items arrive on in_data (list id, value, value flag, close flag) with
// in_valid/in_stall; merged beats leave on out_data with out_valid/out_stall.
// A beat moves when valid is high and stall is low. cfg_wr_en writes the
// number of lists in use (0 counts as one, above eight counts as eight) and
// clears all list state; write it only while the core is idle.
// One item is taken at a time. A refused element gives an error beat first.
// An error beat is loaded into the output register from the drop state, once
// the output register is free. The first merged beat follows the evaluate
// and decide steps, after any error beat. Each further merged beat passes
// the min tree, then the pick, with a refill step ahead of them when the
// emitted list must reload its head from the buffer RAM.
// An item that produces no result still holds the core through the evaluate and decide steps.
// After reset all lists are empty and open and eight lists are in use.
// A stalled output beat holds; the core waits before loading the next one,
// and in_stall stays high until the current item's results are all loaded.
module k_way_sorted_merge_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [kwm_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  kwm_pkg::in_t              in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output kwm_pkg::out_t             out_data
);

    kwm_pkg::cmd_t    cmd;
    kwm_pkg::status_t status;

    kwm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    kwm_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (in_data),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule

@@ verif/kwm_merge_checker.sv @@
// Checker for the k-way sorted merge core: watches the config port and both channels.
// Predicts the merged stream from its own model of the list buffers and compares each beat.
// Depends on kwm_pkg for the payload types and sizes.
module kwm_merge_checker
    import kwm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             in_valid,
    input  logic             in_stall,
    input  in_t              in_data,
    input  logic             out_valid,
    input  logic             out_stall,
    input  out_t             out_data,
    output int               fail_count,
    output int               pending,
    output int               merged_count,
    output int               drop_count,
    output int               batch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [VALUE_WIDTH-1:0] elem_store [MAX_LISTS][BUFFER_DEPTH];
    logic [PTR_W-1:0]              head_pos [MAX_LISTS];
    logic [CNT_W-1:0]              fill_cnt [MAX_LISTS];
    logic [MAX_LISTS-1:0]          closed_mask;
    logic [CFG_W-1:0]              lists_cfg;
    out_t                          out_due [$];

    function automatic int active_count();
        if (lists_cfg == 0)
            return 1;
        if (lists_cfg > MAX_LISTS)
            return MAX_LISTS;
        return int'(lists_cfg);
    endfunction

    task automatic clear_lists();
        for (int i = 0; i < MAX_LISTS; i++)
        begin
            head_pos[i] = '0;
            fill_cnt[i] = '0;
        end
        closed_mask = '0;
    endtask

    task automatic merge_item(input in_t item);
        int                            n;
        int                            id;
        int                            best;
        int                            total;
        bit                            any;
        bit                            blocked;
        bit                            last;
        logic [MAX_LISTS-1:0]          all_mask;
        logic signed [VALUE_WIDTH-1:0] best_val;
        n = active_count();
        id = int'(item.list_id);
        all_mask = MAX_LISTS'((1 << n) - 1);
        if (item.carries_value)
        begin
            if (id < n && !closed_mask[id] && fill_cnt[id] < BUFFER_DEPTH)
            begin
                elem_store[id][(int'(head_pos[id]) + int'(fill_cnt[id])) % BUFFER_DEPTH] =
                    item.value;
                fill_cnt[id] = fill_cnt[id] + 1'b1;
            end
            else
                out_due.push_back('{out_value: item.value, batch_end: 1'b0, dropped: 1'b1});
        end
        if (item.closes_list && id < n)
            closed_mask[id] = 1'b1;
        // Emit heads while every open list in use has something buffered.
        forever
        begin
            any = 1'b0;
            blocked = 1'b0;
            best = 0;
            total = 0;
            best_val = '0;
            for (int i = 0; i < n; i++)
            begin
                if (fill_cnt[i] == 0)
                begin
                    if (!closed_mask[i])
                        blocked = 1'b1;
                end
                else
                begin
                    // Strict compare keeps the lowest list id on equal heads.
                    if (!any || elem_store[i][head_pos[i]] < best_val)
                    begin
                        best_val = elem_store[i][head_pos[i]];
                        best = i;
                    end
                    any = 1'b1;
                    total += int'(fill_cnt[i]);
                end
            end
            if (!any)
            begin
                if ((closed_mask & all_mask) == all_mask)
                    clear_lists();
                break;
            end
            if (blocked)
                break;
            last = ((closed_mask & all_mask) == all_mask) && total == 1;
            head_pos[best] = PTR_W'((int'(head_pos[best]) + 1) % BUFFER_DEPTH);
            fill_cnt[best] = fill_cnt[best] - 1'b1;
            out_due.push_back('{out_value: best_val, batch_end: last, dropped: 1'b0});
            if (last)
            begin
                clear_lists();
                break;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
        begin
            clear_lists();
            lists_cfg = CFG_W'(MAX_LISTS);
            out_due.delete();
            fail_count = 0;
            merged_count = 0;
            drop_count = 0;
            batch_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (out_due.size() == 0)
                begin
                    $display("%0t: unexpected output beat: expected none, got value %0d end %0b drop %0b",
                             $time, out_data.out_value, out_data.batch_end, out_data.dropped);
                    fail_count++;
                end
                else
                begin
                    want = out_due.pop_front();
                    if (out_data.out_value !== want.out_value ||
                        out_data.batch_end !== want.batch_end ||
                        out_data.dropped !== want.dropped)
                    begin
                        $display("%0t: output mismatch: expected value %0d end %0b drop %0b, got value %0d end %0b drop %0b",
                                 $time, want.out_value, want.batch_end, want.dropped,
                                 out_data.out_value, out_data.batch_end, out_data.dropped);
                        fail_count++;
                    end
                    if (want.dropped)
                        drop_count++;
                    else
                        merged_count++;
                    if (want.batch_end)
                        batch_count++;
                end
            end
            // A config write also wipes every list, aborting a batch in progress.
            if (cfg_wr_en)
            begin
                lists_cfg = cfg_wr_data;
                clear_lists();
            end
            if (in_valid && !in_stall)
                merge_item(in_data);
        end
        pending = out_due.size();
    end

endmodule

@@ verif/testbench.sv @@
// Top of the k-way sorted merge testbench: clock, reset, stimulus and the verdict.
// Instantiates k_way_sorted_merge_core and kwm_merge_checker; uses kwm_pkg types.
module testbench;
    import kwm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic signed [VALUE_WIDTH-1:0] V_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic signed [VALUE_WIDTH-1:0] V_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam int PHASE_ITEMS = 47;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    in_t              in_data = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    out_t             out_data;

    int fail_count;
    int pending;
    int merged_count;
    int drop_count;
    int batch_count;
    int idle_pct = 0;
    int stall_pct = 0;
    int sent_count = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    k_way_sorted_merge_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

    kwm_merge_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .merged_count (merged_count),
        .drop_count   (drop_count),
        .batch_count  (batch_count)
    );

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    function automatic in_t mk_item(input int id, input logic signed [VALUE_WIDTH-1:0] v,
                                    input bit has_val, input bit closes);
        in_t item;
        item.list_id = ID_W'(id);
        item.value = v;
        item.carries_value = has_val;
        item.closes_list = closes;
        return item;
    endfunction

    // Offers one beat, with random idle cycles before it, and returns after it is taken.
    task automatic send_item(input in_t item);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_count++;
    endtask

    // The register may only change while the core is idle, so drain first.
    task automatic write_lists(input int val);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= CFG_W'(val);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input int cfg_val, input int idle, input int stall,
                             input int quota);
        int                            n;
        int                            done_items;
        int                            pick;
        int                            len;
        int                            base;
        int                            open_cnt;
        bit                            cl;
        logic signed [VALUE_WIDTH-1:0] v;
        int                            vals [MAX_LISTS][$];
        bit                            done [MAX_LISTS];
        write_lists(cfg_val);
        n = (cfg_val == 0) ? 1 : (cfg_val > MAX_LISTS) ? MAX_LISTS : cfg_val;
        idle_pct = idle;
        stall_pct = stall;
        done_items = 0;
        while (done_items < quota)
        begin
            // One batch: a sorted list per list in use, mostly short, now and then
            // long enough to overrun a buffer.
            for (int i = 0; i < n; i++)
            begin
                vals[i].delete();
                done[i] = 1'b0;
                len = ($urandom_range(9) == 0) ? $urandom_range(6, 11) : $urandom_range(0, 4);
                base = $urandom;
                for (int j = 0; j < len; j++)
                begin
                    case ($urandom_range(3))
                        0: vals[i].push_back($urandom);
                        1: vals[i].push_back(base + $urandom_range(0, 8));
                        2: vals[i].push_back($urandom_range(1) ? V_MAX : V_MIN);
                        default: vals[i].push_back(int'($urandom_range(0, 40)) - 20);
                    endcase
                end
                vals[i].sort();
            end
            open_cnt = n;
            while (open_cnt > 0)
            begin
                // Noise: stray lists, early or repeated closes, out-of-order values.
                if ($urandom_range(99) < 12)
                begin
                    send_item(mk_item($urandom_range(MAX_LISTS - 1), $urandom,
                                      $urandom_range(1), $urandom_range(1)));
                    done_items++;
                end
                pick = $urandom_range(n - 1);
                while (done[pick])
                    pick = (pick + 1) % n;
                if (vals[pick].size() > 0)
                begin
                    v = vals[pick].pop_front();
                    cl = (vals[pick].size() == 0) && $urandom_range(1);
                    send_item(mk_item(pick, v, 1'b1, cl));
                end
                else
                begin
                    cl = 1'b1;
                    send_item(mk_item(pick, $urandom, 1'b0, 1'b1));
                end
                if (cl)
                begin
                    done[pick] = 1'b1;
                    open_cnt--;
                end
                done_items++;
            end
        end
    endtask

    initial
    begin
        int cfg_seq [8];
        int idle_seq [4];
        int stall_seq [4];
        cfg_seq = '{1, 8, 3, 0, 15, 5, 2, 7};
        idle_seq = '{0, 55, 0, 30};
        stall_seq = '{0, 0, 55, 30};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with two lists in use.
        write_lists(2);
        send_item(mk_item(0, V_MAX, 1'b1, 1'b0));
        send_item(mk_item(1, V_MIN, 1'b1, 1'b0));
        send_item(mk_item(1, -1, 1'b1, 1'b0));
        send_item(mk_item(1, 0, 1'b1, 1'b1));
        // Element for an unused list, element for a closed list, close of an
        // unused list, repeated close, then a close-only that ends the batch.
        send_item(mk_item(5, 42, 1'b1, 1'b0));
        send_item(mk_item(1, 7, 1'b1, 1'b0));
        send_item(mk_item(3, 0, 1'b0, 1'b1));
        send_item(mk_item(1, 0, 1'b0, 1'b1));
        send_item(mk_item(0, 0, 1'b0, 1'b1));
        // Fill one buffer while the other list is empty and open; the ninth is refused.
        for (int k = 0; k <= BUFFER_DEPTH; k++)
            send_item(mk_item(0, k, 1'b1, 1'b0));
        // Equal heads across lists, then the last close with nothing buffered.
        send_item(mk_item(1, 3, 1'b1, 1'b1));
        send_item(mk_item(0, 0, 1'b0, 1'b1));
        // Empty batch, an item that does nothing, a refused element with a stray close.
        send_item(mk_item(0, 0, 1'b0, 1'b1));
        send_item(mk_item(1, 0, 1'b0, 1'b1));
        send_item(mk_item(0, $urandom, 1'b0, 1'b0));
        send_item(mk_item(4, V_MAX, 1'b1, 1'b1));

        for (int p = 0; p < 8; p++)
            run_phase(cfg_seq[p], idle_seq[p % 4], stall_seq[p % 4], PHASE_ITEMS);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Ran %0d input beats over nine list counts and four idle patterns;",
                 sent_count);
        $display("checked %0d merged beats, %0d refused-element beats, %0d batch ends.",
                 merged_count, drop_count, batch_count);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #(10_000_000);
        $display("Timed out with %0d beats still outstanding.", pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ k_way_sorted_merge_core.f @@
+incdir+rtl
rtl/kwm_pkg.sv
rtl/kwm_ram.sv
rtl/kwm_ctrl.sv
rtl/kwm_dp.sv
rtl/k_way_sorted_merge_core.sv
verif/kwm_merge_checker.sv
verif/testbench.sv
